// ----- design/sample_rate_divider_search_assert.svh -----
// assertion macros shared by the sample rate divider search block
`ifndef SAMPLE_RATE_DIVIDER_SEARCH_ASSERT_SVH
`define SAMPLE_RATE_DIVIDER_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRDS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SRDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/srds_pkg.sv -----
// types and constants of the sample rate divider search
package srds_pkg;

	localparam int CLK_W = 32;
	localparam int RATE_W = 24;
	localparam int DIV_W = 6;
	localparam int DVSR_W = 18;
	localparam int PROD_W = 2 * DIV_W;

	localparam logic [DIV_W-1:0] BCK_MIN = 6'd2;
	localparam logic [DIV_W-1:0] CLKM_MIN = 6'd5;
	localparam logic [DIV_W-1:0] DIV_MAX = 6'd63;
	localparam logic [CLK_W-1:0] BASE_RESET = 32'd160000000;

	typedef struct packed {
		logic [DIV_W-1:0] bck;
		logic [DIV_W-1:0] clkm;
	} pair_t;

	typedef struct packed {
		logic  start;
		logic  issue;
		logic  load;
		pair_t pair;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_stat_t;

endpackage

// ----- design/srds_div.sv -----
// pipelined restoring divider, one quotient bit per stage, one pair per cycle
module srds_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [srds_pkg::CLK_W-1:0]   base,
	input  logic                         in_v,
	input  logic [srds_pkg::DVSR_W-1:0]  dvsr,
	input  srds_pkg::pair_t              in_pair,
	output logic                         out_v,
	output logic [srds_pkg::RATE_W-1:0]  quot,
	output srds_pkg::pair_t              out_pair,
	output logic                         busy
);
	import srds_pkg::*;

	// divisor is at least 340, so the top eight dividend bits never give a quotient bit
	logic [RATE_W-1:0] v_s;
	logic [DVSR_W-1:0] rem_s  [RATE_W];
	logic [DVSR_W-1:0] dvsr_s [RATE_W];
	logic [RATE_W-1:0] quo_s  [RATE_W];
	pair_t             pair_s [RATE_W];

	for (genvar k = 0; k < RATE_W; k++) begin : g_stg
		logic              v_in;
		logic [DVSR_W-1:0] rem_in;
		logic [DVSR_W-1:0] dvsr_in;
		logic [RATE_W-1:0] quo_in;
		pair_t             pair_in;
		logic [DVSR_W:0]   trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign rem_in  = DVSR_W'(base[CLK_W-1:RATE_W]);
			assign dvsr_in = dvsr;
			assign quo_in  = '0;
			assign pair_in = in_pair;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign dvsr_in = dvsr_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign pair_in = pair_s[k-1];
		end

		assign trial = {rem_in, base[RATE_W-1-k]};
		assign ge    = trial >= {1'b0, dvsr_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? DVSR_W'(trial - {1'b0, dvsr_in}) : trial[DVSR_W-1:0];
			dvsr_s[k] <= dvsr_in;
			quo_s[k]  <= {quo_in[RATE_W-2:0], ge};
			pair_s[k] <= pair_in;
		end
	end

	assign out_v    = v_s[RATE_W-1];
	assign quot     = quo_s[RATE_W-1];
	assign out_pair = pair_s[RATE_W-1];
	assign busy     = |v_s;

endmodule

// ----- design/srds_dp.sv -----
// datapath: base clock register, divisor, divider, distance compare, best pair
module srds_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [srds_pkg::CLK_W-1:0]   cfg_wdata,
	input  logic [srds_pkg::RATE_W-1:0]  target_rate,
	input  srds_pkg::ctrl_cmd_t          cmd,
	output srds_pkg::dp_stat_t           stat,
	output logic [srds_pkg::DIV_W-1:0]   bit_clock_div,
	output logic [srds_pkg::DIV_W-1:0]   master_clock_div,
	output logic [srds_pkg::RATE_W-1:0]  achieved_rate
);
	import srds_pkg::*;

	logic [CLK_W-1:0]  base_q;
	logic [RATE_W-1:0] target_q;

	logic              iss_v_s1;
	logic [DVSR_W-1:0] dvsr_s1;
	pair_t             pair_s1;
	logic [PROD_W-1:0] prod;

	logic              div_v;
	logic [RATE_W-1:0] div_quot;
	pair_t             div_pair;
	logic              div_busy;

	logic              dif_v_s2;
	logic [RATE_W-1:0] dif_s2;
	logic [RATE_W-1:0] rate_s2;
	pair_t             pair_s2;
	logic [RATE_W-1:0] delta;

	logic [RATE_W-1:0] best_dist_q;
	logic [RATE_W-1:0] best_rate_q;
	pair_t             best_pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// divisor = bck * clkm * 17 bits * 2 channels
	assign prod = cmd.pair.bck * cmd.pair.clkm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_v_s1 <= 1'b0;
			dif_v_s2 <= 1'b0;
		end else begin
			iss_v_s1 <= cmd.issue;
			dif_v_s2 <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		dvsr_s1 <= DVSR_W'({prod, 5'b0}) + DVSR_W'({prod, 1'b0});
		pair_s1 <= cmd.pair;
	end

	srds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.base     (base_q),
		.in_v     (iss_v_s1),
		.dvsr     (dvsr_s1),
		.in_pair  (pair_s1),
		.out_v    (div_v),
		.quot     (div_quot),
		.out_pair (div_pair),
		.busy     (div_busy)
	);

	assign delta = (target_q >= div_quot) ? (target_q - div_quot) : (div_quot - target_q);

	always_ff @(posedge clk) begin
		dif_s2  <= delta;
		rate_s2 <= div_quot;
		pair_s2 <= div_pair;
	end

	// best rate starts at zero, so its distance is the target itself
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q    <= target_rate;
			best_dist_q <= target_rate;
			best_rate_q <= '0;
			best_pair_q <= '0;
		end else if (dif_v_s2 && (dif_s2 < best_dist_q)) begin
			best_dist_q <= dif_s2;
			best_rate_q <= rate_s2;
			best_pair_q <= pair_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bit_clock_div    <= best_pair_q.bck;
			master_clock_div <= best_pair_q.clkm;
			achieved_rate    <= best_rate_q;
		end
	end

	assign stat.busy = iss_v_s1 | div_busy | dif_v_s2;

endmodule

// ----- design/srds_ctrl.sv -----
// controller: pair sweep, pipeline drain and result handoff
module srds_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  srds_pkg::dp_stat_t   stat,
	output srds_pkg::ctrl_cmd_t  cmd
);
	import srds_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [DIV_W-1:0] bck_q;
	logic [DIV_W-1:0] clkm_q;
	logic             out_valid_q;
	logic             load;

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (clkm_q == DIV_MAX && bck_q == DIV_MAX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hand over once the output register is free
				if (!out_valid_q || !out_stall) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bck_q       <= BCK_MIN;
			clkm_q      <= CLKM_MIN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				bck_q  <= BCK_MIN;
				clkm_q <= CLKM_MIN;
			end else if (state_q == ST_RUN) begin
				if (clkm_q == DIV_MAX) begin
					clkm_q <= CLKM_MIN;
					bck_q  <= bck_q + 1'b1;
				end else begin
					clkm_q <= clkm_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign cmd.start     = (state_q == ST_IDLE) && in_valid;
	assign cmd.issue     = (state_q == ST_RUN);
	assign cmd.load      = load;
	assign cmd.pair.bck  = bck_q;
	assign cmd.pair.clkm = clkm_q;

endmodule

// ----- design/sample_rate_divider_search.sv -----
// top level of the sample rate divider search
// Takes a target sample rate and sweeps all 3658 divider pairs (bit clock 2..63 outer,
// master clock 5..63 inner), feeding one pair per cycle into a 24-stage pipelined divider
// that computes base_clock_hz / (bck * clkm * 34); the closest rate wins, first on a tie,
// and all zeros come back when no pair beats rate 0. An item goes through acceptance,
// issue of all pairs, divider and compare pipeline drain and handoff, with one item in
// flight at a time. The next item is taken while the previous result still waits on
// out_stall. The user must write base_clock_hz through cfg_we / cfg_wdata only while
// the block is idle; the block itself does not enforce it.
module sample_rate_divider_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [srds_pkg::CLK_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [srds_pkg::RATE_W-1:0]  target_rate,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [srds_pkg::DIV_W-1:0]   bit_clock_div,
	output logic [srds_pkg::DIV_W-1:0]   master_clock_div,
	output logic [srds_pkg::RATE_W-1:0]  achieved_rate
);
	import srds_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	srds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	srds_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.target_rate      (target_rate),
		.cmd              (cmd),
		.stat             (stat),
		.bit_clock_div    (bit_clock_div),
		.master_clock_div (master_clock_div),
		.achieved_rate    (achieved_rate)
	);

`include "sample_rate_divider_search_assert.svh"

	`SRDS_ASSERT_IMPL(a_idle_empty, !in_stall, !stat.busy, "item taken while pipeline busy")
	`SRDS_ASSERT_NEXT(a_issue_busy, cmd.issue, stat.busy, "issued pair not in pipeline")
	`SRDS_ASSERT_IMPL(a_pair_zero, out_valid, (bit_clock_div == '0) == (master_clock_div == '0), "one divider zero, other not")
	`SRDS_ASSERT_IMPL(a_pair_range, out_valid && (bit_clock_div != '0), (bit_clock_div >= BCK_MIN) && (master_clock_div >= CLKM_MIN), "divider below sweep range")

endmodule

// ----- test/sample_rate_divider_search_tb.sv -----
// self-checking testbench for the sample rate divider search block
module sample_rate_divider_search_tb;
	import srds_pkg::*;

	localparam int FRAME_BITS = 17 * 2;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 12000;
	localparam int WATCHDOG_LIMIT = 60000;

	typedef struct packed {
		logic [DIV_W-1:0]  bck;
		logic [DIV_W-1:0]  clkm;
		logic [RATE_W-1:0] rate;
	} divider_choice_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CLK_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [RATE_W-1:0] target_rate = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DIV_W-1:0]  bit_clock_div;
	logic [DIV_W-1:0]  master_clock_div;
	logic [RATE_W-1:0] achieved_rate;

	logic [RATE_W-1:0] pending_targets[$];
	divider_choice_t   awaited_choices[$];
	logic [CLK_W-1:0]  base_clock_mirror = BASE_RESET;

	int errors = 0;
	int targets_sent = 0;
	int choices_checked = 0;
	int settings_used = 1;
	int gap_left = 0;
	int stall_left = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int quiet_cycles = 0;
	divider_choice_t rx_want;

	sample_rate_divider_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_rate(target_rate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bit_clock_div(bit_clock_div),
		.master_clock_div(master_clock_div),
		.achieved_rate(achieved_rate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// full sweep of divider pairs, strict improvement keeps the first on a tie
	function automatic divider_choice_t best_divider_pair(input logic [RATE_W-1:0] target,
			input logic [CLK_W-1:0] clk_hz);
		divider_choice_t best;
		longint unsigned rate;
		longint unsigned err;
		longint unsigned best_err;
		int b;
		int m;
		best = '0;
		best_err = target;
		for (b = BCK_MIN; b <= DIV_MAX; b++) begin
			for (m = CLKM_MIN; m <= DIV_MAX; m++) begin
				rate = longint'(clk_hz) / longint'(b * m * FRAME_BITS);
				err = (rate > target) ? rate - target : target - rate;
				if (err < best_err) begin
					best_err = err;
					best.bck = b[DIV_W-1:0];
					best.clkm = m[DIV_W-1:0];
					best.rate = rate[RATE_W-1:0];
				end
			end
		end
		return best;
	endfunction

	// mostly targets close to a reachable rate, some midpoints and plain noise
	function automatic logic [RATE_W-1:0] pick_target(input logic [CLK_W-1:0] clk_hz);
		int unsigned r;
		int unsigned b;
		int unsigned m;
		longint v;
		longint q1;
		longint q2;
		longint top;
		r = $urandom_range(0, 99);
		b = $urandom_range(BCK_MIN, DIV_MAX);
		m = $urandom_range(CLKM_MIN, DIV_MAX - 1);
		q1 = longint'(clk_hz) / longint'(b * m * FRAME_BITS);
		q2 = longint'(clk_hz) / longint'(b * (m + 1) * FRAME_BITS);
		top = longint'(clk_hz) / longint'(BCK_MIN * CLKM_MIN * FRAME_BITS);
		if (r < 55) begin
			v = q1 + longint'($urandom_range(0, 8)) - 4;
		end else if (r < 65) begin
			v = (q1 + q2) / 2;
		end else if (r < 80) begin
			v = $urandom_range(0, top[31:0]);
		end else begin
			v = $urandom() & 32'hFF_FFFF;
		end
		if (v < 0)
			v = 0;
		if (v > 64'hFF_FFFF)
			v = 64'hFF_FFFF;
		return v[RATE_W-1:0];
	endfunction

	function automatic int next_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(30, 300);
	endfunction

	// sender side
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall) begin
				// item held until the block takes it
			end else if (in_valid) begin
				awaited_choices.push_back(best_divider_pair(target_rate, base_clock_mirror));
				targets_sent++;
				gap_left = next_gap();
				if (gap_left == 0 && pending_targets.size() != 0) begin
					target_rate <= pending_targets.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end else if (gap_left != 0) begin
				gap_left = gap_left - 1;
			end else if (pending_targets.size() != 0) begin
				in_valid <= 1'b1;
				target_rate <= pending_targets.pop_front();
			end
		end
	end

	// receiver side
	always @(posedge clk) begin
		int unsigned r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				choices_checked++;
				if (awaited_choices.size() == 0) begin
					report_mismatch($sformatf("unexpected result bck=%0d clkm=%0d rate=%0d",
						bit_clock_div, master_clock_div, achieved_rate));
				end else begin
					rx_want = awaited_choices.pop_front();
					if (bit_clock_div !== rx_want.bck)
						report_mismatch($sformatf("bit_clock_div %0d, wanted %0d",
							bit_clock_div, rx_want.bck));
					if (master_clock_div !== rx_want.clkm)
						report_mismatch($sformatf("master_clock_div %0d, wanted %0d",
							master_clock_div, rx_want.clkm));
					if (achieved_rate !== rx_want.rate)
						report_mismatch($sformatf("achieved_rate %0d, wanted %0d",
							achieved_rate, rx_want.rate));
				end
			end
			if (hold_served != hold_asked) begin
				// long hold-off so the block backs up into its input
				hold_served++;
				stall_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left = stall_left - 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
					stall_left = $urandom_range(0, 30);
				end else if (r < 92) begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(1, 4);
				end else begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(40, 400);
				end
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", quiet_cycles);
				$display("sample_rate_divider_search_tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic drain_and_settle();
		@(negedge clk);
		while (pending_targets.size() != 0 || in_valid || awaited_choices.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_base_clock(input logic [CLK_W-1:0] clk_hz);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= clk_hz;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		base_clock_mirror = clk_hz;
		settings_used++;
	endtask

	task automatic queue_random_targets(input int count);
		repeat (count) pending_targets.push_back(pick_target(base_clock_mirror));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset clock: field extremes, common audio rates, rates above the highest reachable one
		pending_targets.push_back(24'd0);
		pending_targets.push_back(24'd1);
		pending_targets.push_back(24'hFF_FFFF);
		pending_targets.push_back(24'd8000);
		pending_targets.push_back(24'd11025);
		pending_targets.push_back(24'd16000);
		pending_targets.push_back(24'd22050);
		pending_targets.push_back(24'd44100);
		pending_targets.push_back(24'd48000);
		pending_targets.push_back(24'd96000);
		pending_targets.push_back(24'd4705882);
		pending_targets.push_back(24'd4705881);
		pending_targets.push_back(24'd2352941);
		pending_targets.push_back(24'h80_0000);
		pending_targets.push_back(24'h7F_FFFF);
		pending_targets.push_back(24'h55_5555);
		pending_targets.push_back(24'hAA_AAAA);
		drain_and_settle();

		// zero base clock: every quotient is zero
		write_base_clock(32'd0);
		pending_targets.push_back(24'd0);
		pending_targets.push_back(24'd3);
		pending_targets.push_back(24'hFF_FFFF);
		queue_random_targets(10);
		drain_and_settle();

		write_base_clock(32'hFFFF_FFFF);
		pending_targets.push_back(24'hFF_FFFF);
		pending_targets.push_back(24'd12632256);
		pending_targets.push_back(24'd0);
		queue_random_targets(15);
		drain_and_settle();

		write_base_clock(32'd1);
		pending_targets.push_back(24'd0);
		pending_targets.push_back(24'd1);
		queue_random_targets(10);
		drain_and_settle();

		write_base_clock(BASE_RESET);
		hold_asked++;
		queue_random_targets(30);
		drain_and_settle();

		write_base_clock($urandom());
		queue_random_targets(25);
		drain_and_settle();

		write_base_clock($urandom_range(1000000, 100000000));
		queue_random_targets(25);
		drain_and_settle();

		$display("covered %0d targets over %0d base clock settings", targets_sent,
			settings_used);
		$display("checked %0d divider choices, one long receiver hold-off", choices_checked);
		if (awaited_choices.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_choices.size()));
		if (errors == 0)
			$display("sample_rate_divider_search_tb: clean");
		else
			$display("sample_rate_divider_search_tb: errors");
		$finish;
	end

endmodule
